/* design/rgsi_pkg.sv */
// shared types and constants for the rtp gap silence inserter
`default_nettype none

package rgsi_pkg;

  // playout buffer depth in blocks
  localparam int unsigned BUFFER_BLOCKS = 32;

  // widths of the result and register fields
  localparam int unsigned OCC_W  = 6;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned FL_W   = 4;
  localparam int unsigned PRE_W  = 6;
  localparam int unsigned DATA_W = 6;

  // silence run counter, saturates well above any run that can fit
  localparam int unsigned SIL_W = 7;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_TIMER  = 2'd1,
    OP_SINK   = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_PACKET  = 3'd0,
    ACT_SILENCE = 3'd1,
    ACT_DISCARD = 3'd2,
    ACT_PLAY    = 3'd3,
    ACT_NONE    = 3'd4
  } action_t;

  typedef enum logic {
    REG_FRAGMENT_LOG2  = 1'b0,
    REG_PREFILL_BLOCKS = 1'b1
  } reg_index_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic phase;
    logic classify;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

/* design/rgsi_ctrl.sv */
// controller state machine of the rtp gap silence inserter
`default_nettype none

module rgsi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  rgsi_pkg::status_t     status,
  output rgsi_pkg::cmd_t        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PHASE    = 4'b0010,
    ST_CLASSIFY = 4'b0100,
    ST_RUN      = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_PHASE;
        end
      end
      ST_PHASE: begin
        cmd.phase  = 1'b1;
        state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_next   = ST_RUN;
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/rgsi_datapath.sv */
// datapath of the rtp gap silence inserter: state, gap arithmetic, result register
`default_nettype none

module rgsi_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  rgsi_pkg::cmd_t                     cmd,
  output rgsi_pkg::status_t                  status,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [rgsi_pkg::DATA_W-1:0]   cfg_data,
  input  wire logic [1:0]                    opcode,
  input  wire logic [rgsi_pkg::SEQ_W-1:0]    seq_number,
  input  wire logic [rgsi_pkg::TS_W-1:0]     rtp_timestamp,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         action,
  output logic [rgsi_pkg::SEQ_W-1:0]         lost_now,
  output logic [rgsi_pkg::OCC_W-1:0]         occupancy,
  output logic                               buffer_full,
  output logic                               last
);

  localparam logic [rgsi_pkg::OCC_W-1:0] BUF =
    rgsi_pkg::OCC_W'(rgsi_pkg::BUFFER_BLOCKS);
  localparam logic [rgsi_pkg::SIL_W-1:0] SIL_MAX = '1;

  // configuration
  logic [rgsi_pkg::FL_W-1:0]  frag_log2;
  logic [rgsi_pkg::PRE_W-1:0] prefill;

  // event and kept state
  logic [1:0]                 op;
  logic [rgsi_pkg::SEQ_W-1:0] seq;
  logic [rgsi_pkg::TS_W-1:0]  ts;
  logic [rgsi_pkg::SEQ_W-1:0] prev_seq;
  logic [rgsi_pkg::TS_W-1:0]  prev_ts;
  logic                       steady;
  logic [rgsi_pkg::OCC_W-1:0] count;

  // per event working values
  logic [rgsi_pkg::SEQ_W-1:0] gap;
  logic [rgsi_pkg::TS_W-1:0]  expect_ts;
  logic [rgsi_pkg::SEQ_W-1:0] lost;
  logic [rgsi_pkg::SIL_W-1:0] sil_cnt;
  rgsi_pkg::action_t          fin;

  // phase step logic
  logic [rgsi_pkg::OCC_W-1:0] thr;
  logic [rgsi_pkg::SEQ_W-1:0] gap_next;
  logic [rgsi_pkg::SEQ_W:0]   kk;
  logic [rgsi_pkg::TS_W-1:0]  step;
  logic [rgsi_pkg::TS_W-1:0]  frag;

  // classify logic
  logic [rgsi_pkg::TS_W-1:0]  dt;
  logic [rgsi_pkg::TS_W-1:0]  dt_blocks;
  logic [rgsi_pkg::SIL_W:0]   sil_sum;
  logic                       sil_big;
  logic [rgsi_pkg::SIL_W-1:0] sil_sat;
  logic [rgsi_pkg::SIL_W-1:0] c_sil;
  rgsi_pkg::action_t          c_fin;
  logic [rgsi_pkg::SEQ_W-1:0] c_lost;

  // result logic
  logic                       store_ok;
  logic                       e_store;
  logic                       e_last;
  rgsi_pkg::action_t          e_act;
  logic [rgsi_pkg::OCC_W-1:0] e_count;

  assign frag     = rgsi_pkg::TS_W'(1) << frag_log2;
  assign thr      = (rgsi_pkg::OCC_W'(prefill) > BUF) ? BUF : rgsi_pkg::OCC_W'(prefill);
  assign gap_next = seq - prev_seq - rgsi_pkg::SEQ_W'(1);
  assign kk       = {1'b0, gap_next} + (rgsi_pkg::SEQ_W+1)'(1);
  assign step     = rgsi_pkg::TS_W'(kk) << frag_log2;

  assign dt        = ts - expect_ts;
  assign dt_blocks = dt >> frag_log2;
  assign sil_sum   = (rgsi_pkg::SIL_W+1)'(dt_blocks[rgsi_pkg::SIL_W-1:0])
                   + (rgsi_pkg::SIL_W+1)'(gap[rgsi_pkg::SIL_W-1:0]);
  assign sil_big   = (|dt_blocks[rgsi_pkg::TS_W-1:rgsi_pkg::SIL_W])
                   | (|gap[rgsi_pkg::SEQ_W-1:rgsi_pkg::SIL_W])
                   | sil_sum[rgsi_pkg::SIL_W];
  assign sil_sat   = sil_big ? SIL_MAX : sil_sum[rgsi_pkg::SIL_W-1:0];

  always_comb begin
    c_sil  = '0;
    c_lost = '0;
    c_fin  = rgsi_pkg::ACT_NONE;
    case (op)
      rgsi_pkg::OP_PACKET: begin
        if (!steady) begin
          c_fin = rgsi_pkg::ACT_PACKET;
        end else if (gap[rgsi_pkg::SEQ_W-1]) begin
          c_fin = rgsi_pkg::ACT_DISCARD;
        end else begin
          c_lost = gap;
          if (dt[rgsi_pkg::TS_W-1]) begin
            c_fin = rgsi_pkg::ACT_DISCARD;
          end else begin
            c_fin = rgsi_pkg::ACT_PACKET;
            c_sil = sil_sat;
          end
        end
      end
      rgsi_pkg::OP_TIMER: begin
        if (steady) begin
          c_fin = rgsi_pkg::ACT_SILENCE;
        end
      end
      rgsi_pkg::OP_SINK: begin
        if (steady && (count != '0)) begin
          c_fin = rgsi_pkg::ACT_PLAY;
        end
      end
      default: begin
        c_fin = rgsi_pkg::ACT_NONE;
      end
    endcase
  end

  // next result
  assign store_ok = count < BUF;

  always_comb begin
    if (sil_cnt != '0) begin
      e_act   = rgsi_pkg::ACT_SILENCE;
      e_store = 1'b1;
      e_last  = !store_ok;
    end else begin
      e_act   = fin;
      e_store = (fin == rgsi_pkg::ACT_PACKET) || (fin == rgsi_pkg::ACT_SILENCE);
      e_last  = 1'b1;
    end
    if (e_store && store_ok) begin
      e_count = count + rgsi_pkg::OCC_W'(1);
    end else if (e_act == rgsi_pkg::ACT_PLAY) begin
      e_count = count - rgsi_pkg::OCC_W'(1);
    end else begin
      e_count = count;
    end
  end

  assign status.out_free  = !out_valid || out_ready;
  assign status.emit_last = e_last;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frag_log2 <= rgsi_pkg::FL_W'(8);
      prefill   <= rgsi_pkg::PRE_W'(4);
      prev_seq  <= '0;
      prev_ts   <= '0;
      steady    <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rgsi_pkg::REG_FRAGMENT_LOG2:  frag_log2 <= cfg_data[rgsi_pkg::FL_W-1:0];
          rgsi_pkg::REG_PREFILL_BLOCKS: prefill   <= cfg_data[rgsi_pkg::PRE_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.phase && (count >= thr)) begin
        steady <= 1'b1;
      end
      if (cmd.classify && (op == rgsi_pkg::OP_PACKET)) begin
        prev_seq <= seq;
        prev_ts  <= ts;
      end
      if (cmd.emit) begin
        count <= e_count;
        if ((sil_cnt == '0) && (fin == rgsi_pkg::ACT_SILENCE) && store_ok) begin
          prev_ts <= prev_ts + frag;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op  <= opcode;
      seq <= seq_number;
      ts  <= rtp_timestamp;
    end
    if (cmd.phase) begin
      gap       <= gap_next;
      expect_ts <= prev_ts + step;
    end
    if (cmd.classify) begin
      fin     <= c_fin;
      sil_cnt <= c_sil;
      lost    <= c_lost;
    end else if (cmd.emit && (sil_cnt != '0) && store_ok) begin
      sil_cnt <= sil_cnt - rgsi_pkg::SIL_W'(1);
    end
    if (cmd.emit) begin
      action      <= e_act;
      lost_now    <= lost;
      occupancy   <= e_count;
      buffer_full <= e_store && !store_ok;
      last        <= e_last;
    end
  end

endmodule

`default_nettype wire

/* design/rtp_gap_silence_inserter_core.sv */
// top level of the rtp gap silence inserter: controller plus datapath
`default_nettype none

// Playout controller for received rtp audio. Each input transfer is one event
// (packet received, playout timer expired, sink ready) and gives a run of one
// or more result transfers: store packet, store silence, discard, play or none,
// with last set on the final one. In steady phase sequence gaps and timestamp
// gaps become silence blocks ahead of the packet; a store into a full buffer is
// reported with buffer_full set and ends the run. An event passes through
// capture, phase check with sequence gap, and timestamp gap and run length,
// after which the run state gives its results in turn; the result register
// is the pacing unit, and a stalled output holds the run. Configuration
// writes land at once and are meant for when no event is in flight.

module rtp_gap_silence_inserter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_index,
  input  wire logic [rgsi_pkg::DATA_W-1:0]   cfg_data,
  // event input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    opcode,
  input  wire logic [rgsi_pkg::SEQ_W-1:0]    seq_number,
  input  wire logic [rgsi_pkg::TS_W-1:0]     rtp_timestamp,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         action,
  output logic [rgsi_pkg::SEQ_W-1:0]         lost_now,
  output logic [rgsi_pkg::OCC_W-1:0]         occupancy,
  output logic                               buffer_full,
  output logic                               last
);

  rgsi_pkg::cmd_t    cmd;
  rgsi_pkg::status_t status;

  // sequencing of each event
  rgsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // kept state, gap arithmetic and the result register
  rgsi_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .seq_number    (seq_number),
    .rtp_timestamp (rtp_timestamp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .lost_now      (lost_now),
    .occupancy     (occupancy),
    .buffer_full   (buffer_full),
    .last          (last)
  );

  // occupancy never runs past the buffer depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= rgsi_pkg::OCC_W'(rgsi_pkg::BUFFER_BLOCKS)))
    else $error("occupancy above buffer depth");

  // a failed store always closes the run
  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_full) |-> last)
    else $error("full store not marked last");

  // no new event is taken while a run is still being produced
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("event taken back to back");

  // only stores can report a full buffer
  a_full_store: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_full) |->
      ((action == rgsi_pkg::ACT_PACKET) || (action == rgsi_pkg::ACT_SILENCE)))
    else $error("full flag on a non-store result");

endmodule

`default_nettype wire

/* dv/rgsi_playout_checker.sv */
`timescale 1ns / 1ps
// playout checker: predicts the command run of every event and compares each result transfer
module rgsi_playout_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [rgsi_pkg::DATA_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 opcode,
  input  logic [rgsi_pkg::SEQ_W-1:0] seq_number,
  input  logic [rgsi_pkg::TS_W-1:0]  rtp_timestamp,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [2:0]                 action,
  input  logic [rgsi_pkg::SEQ_W-1:0] lost_now,
  input  logic [rgsi_pkg::OCC_W-1:0] occupancy,
  input  logic                       buffer_full,
  input  logic                       last,
  output int                         faults,
  output int                         outstanding
);
  import rgsi_pkg::*;

  typedef struct packed {
    action_t            act;
    logic [SEQ_W-1:0]   lost;
    logic [OCC_W-1:0]   occ;
    logic               full;
    logic               fin;
  } playout_cmd_t;

  playout_cmd_t cmd_q[$];
  playout_cmd_t want;

  // predicted block state and register copies
  logic [FL_W-1:0]  frag_log2 = 4'd8;
  logic [PRE_W-1:0] prefill   = 6'd4;
  logic [SEQ_W-1:0] last_seq  = '0;
  logic [TS_W-1:0]  last_ts   = '0;
  logic             steady    = 1'b0;
  int unsigned      fill      = 0;
  int               mism      = 0;

  assign faults = mism;

  function automatic void push_cmd(action_t act, logic [SEQ_W-1:0] lost, logic full);
    playout_cmd_t c;
    c.act  = act;
    c.lost = lost;
    c.occ  = fill[OCC_W-1:0];
    c.full = full;
    c.fin  = 1'b0;
    cmd_q.push_back(c);
  endfunction

  function automatic bit store_block(action_t act, logic [SEQ_W-1:0] lost);
    if (fill < BUFFER_BLOCKS) begin
      fill = fill + 1;
      push_cmd(act, lost, 1'b0);
      return 1'b1;
    end
    push_cmd(act, lost, 1'b1);
    return 1'b0;
  endfunction

  // silence run ahead of the packet, cut short by a full buffer
  function automatic void fill_gap(longint unsigned n, logic [SEQ_W-1:0] lost);
    longint unsigned i;
    for (i = 0; i < n; i++) begin
      if (!store_block(ACT_SILENCE, lost)) return;
    end
    void'(store_block(ACT_PACKET, lost));
  endfunction

  function automatic void predict_event(logic [1:0] op, logic [SEQ_W-1:0] seq,
                                        logic [TS_W-1:0] ts);
    int unsigned      thr;
    logic [TS_W-1:0]  step;
    logic [TS_W-1:0]  dt;
    logic [SEQ_W-1:0] gap;
    logic [TS_W-1:0]  span;
    longint unsigned  n;
    playout_cmd_t     tail;
    thr  = (32'(prefill) > BUFFER_BLOCKS) ? BUFFER_BLOCKS : 32'(prefill);
    step = 32'd1 << frag_log2;
    if (!steady && fill >= thr) steady = 1'b1;
    if (op == OP_PACKET) begin
      if (!steady) begin
        void'(store_block(ACT_PACKET, '0));
      end else begin
        gap = seq - last_seq - 16'd1;
        if (gap == '0) begin
          dt = ts - last_ts - step;
          if (dt == '0) void'(store_block(ACT_PACKET, '0));
          else if (!dt[31]) fill_gap(64'(dt >> frag_log2), '0);
          else push_cmd(ACT_DISCARD, '0, 1'b0);
        end else if (!gap[15]) begin
          span = ({16'd0, gap} + 32'd1) * step;
          dt = ts - last_ts - span;
          if (dt[31]) begin
            push_cmd(ACT_DISCARD, gap, 1'b0);
          end else begin
            n = 64'(dt >> frag_log2);
            fill_gap(n + 64'(gap), gap);
          end
        end else begin
          push_cmd(ACT_DISCARD, '0, 1'b0);
        end
      end
      last_seq = seq;
      last_ts  = ts;
    end else if (op == OP_TIMER && steady) begin
      if (store_block(ACT_SILENCE, '0)) last_ts = last_ts + step;
    end else if (op == OP_SINK && steady && fill > 0) begin
      fill = fill - 1;
      push_cmd(ACT_PLAY, '0, 1'b0);
    end else begin
      push_cmd(ACT_NONE, '0, 1'b0);
    end
    tail = cmd_q.pop_back();
    tail.fin = 1'b1;
    cmd_q.push_back(tail);
  endfunction

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, got_v);
      mism++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cmd_q.delete();
      frag_log2 = 4'd8;
      prefill   = 6'd4;
      last_seq  = '0;
      last_ts   = '0;
      steady    = 1'b0;
      fill      = 0;
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual action %0d",
                   $time, action);
          mism++;
        end else begin
          want = cmd_q.pop_front();
          check_field("action", 32'(want.act), 32'(action));
          check_field("lost_now", 32'(want.lost), 32'(lost_now));
          check_field("occupancy", 32'(want.occ), 32'(occupancy));
          check_field("buffer_full", 32'(want.full), 32'(buffer_full));
          check_field("last", 32'(want.fin), 32'(last));
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == REG_FRAGMENT_LOG2) frag_log2 = cfg_data[FL_W-1:0];
        else prefill = cfg_data[PRE_W-1:0];
      end
      if (in_valid && in_ready) predict_event(opcode, seq_number, rtp_timestamp);
      outstanding <= cmd_q.size();
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// testbench top: drives events and register writes into the playout controller, gives the verdict
module tb_top;
  import rgsi_pkg::*;

  // opcode with no meaning to the block, answered with action none
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = 1'b0;
  logic [DATA_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          opcode = '0;
  logic [SEQ_W-1:0]    seq_number = '0;
  logic [TS_W-1:0]     rtp_timestamp = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          action;
  logic [SEQ_W-1:0]    lost_now;
  logic [OCC_W-1:0]    occupancy;
  logic                buffer_full;
  logic                last;

  int                  faults;
  int                  outstanding;
  int                  cycle_cnt = 0;

  // stimulus-side view of the stream: next sequence and timestamp to build on
  logic [SEQ_W-1:0]    cur_seq = '0;
  logic [TS_W-1:0]     cur_ts = '0;
  logic [FL_W-1:0]     frag_cfg = 4'd8;
  // when set, neither side idles or stalls
  logic                calm = 1'b0;

  always #5 clk = ~clk;

  rtp_gap_silence_inserter_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .seq_number    (seq_number),
    .rtp_timestamp (rtp_timestamp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .lost_now      (lost_now),
    .occupancy     (occupancy),
    .buffer_full   (buffer_full),
    .last          (last)
  );

  rgsi_playout_checker playout_chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .seq_number    (seq_number),
    .rtp_timestamp (rtp_timestamp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .lost_now      (lost_now),
    .occupancy     (occupancy),
    .buffer_full   (buffer_full),
    .last          (last),
    .faults        (faults),
    .outstanding   (outstanding)
  );

  // sink side: stalls with a chance of roughly 30 in a hundred unless calm
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 30);
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // one event transfer, with an occasional idle gap ahead of it
  task automatic send(logic [1:0] op, logic [SEQ_W-1:0] seq, logic [TS_W-1:0] ts);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    seq_number    <= seq;
    rtp_timestamp <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender back until every predicted result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // both registers, written only once the block has gone quiet
  task automatic set_config(logic [FL_W-1:0] fl, logic [PRE_W-1:0] pre);
    logic [1:0] junk;
    junk = 2'($urandom);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAGMENT_LOG2;
    // spare upper bits carry noise, only the low four count
    cfg_data  <= {junk, fl};
    @(posedge clk);
    cfg_index <= REG_PREFILL_BLOCKS;
    cfg_data  <= pre;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frag_cfg = fl;
  endtask

  // mostly a well-formed stream with sink requests to keep the buffer moving,
  // the rest is losses, gaps, stale packets and noise
  task automatic random_event();
    int unsigned      pick;
    int unsigned      skip;
    logic [TS_W-1:0]  step;
    logic [1:0]       op;
    logic [SEQ_W-1:0] s;
    logic [TS_W-1:0]  t;
    step = 32'd1 << frag_cfg;
    pick = $urandom_range(99);
    skip = $urandom_range(2, 1);
    op = OP_PACKET;
    s = SEQ_W'($urandom);
    t = $urandom;
    if (pick < 25) begin
      // in order, next block
      cur_seq = cur_seq + 16'd1;
      cur_ts  = cur_ts + step;
    end else if (pick < 31) begin
      // lost packets, timestamp on or past the expected point
      cur_seq = cur_seq + 16'd1 + SEQ_W'(skip);
      cur_ts  = cur_ts + step * (1 + skip + $urandom_range(1, 0));
    end else if (pick < 36) begin
      // timestamp jump with no loss, part blocks included
      cur_seq = cur_seq + 16'd1;
      cur_ts  = cur_ts + step * $urandom_range(3, 2) + $urandom_range(step - 1, 0);
    end else if (pick < 40) begin
      // duplicate or late arrival
      cur_seq = cur_seq - SEQ_W'($urandom_range(3, 0));
      cur_ts  = $urandom;
    end else if (pick < 43) begin
      // loss with a timestamp earlier than the gap allows
      cur_seq = cur_seq + 16'd2;
      cur_ts  = cur_ts + step;
    end else if (pick < 46) begin
      cur_seq = s;
      cur_ts  = t;
    end else if (pick < 52) begin
      op = OP_TIMER;
      cur_ts = cur_ts + step;
    end else if (pick < 97) begin
      op = OP_SINK;
    end else begin
      op = OP_UNUSED;
    end
    if (op == OP_PACKET) begin
      s = cur_seq;
      t = cur_ts;
    end
    send(op, s, t);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset settings (256 samples per block, prefill of four)
    // timer, sink and unknown opcode while still filling: no action
    send(OP_SINK, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_TIMER, 16'h0000, 32'h0000_0000);
    send(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    // prefill packets, sequence and timestamp both wrap on the way
    send(OP_PACKET, 16'hFFFC, 32'hFFFF_FD00);
    send(OP_PACKET, 16'hFFFD, 32'hFFFF_FE00);
    send(OP_PACKET, 16'hFFFE, 32'hFFFF_FF00);
    send(OP_PACKET, 16'hFFFF, 32'h0000_0000);
    // steady from here: clean successor
    send(OP_PACKET, 16'h0000, 32'h0000_0100);
    // three blocks of timestamp gap become silence
    send(OP_PACKET, 16'h0001, 32'h0000_0500);
    // gap shorter than one block: packet only
    send(OP_PACKET, 16'h0002, 32'h0000_067F);
    // two packets lost, timestamp exactly as expected
    send(OP_PACKET, 16'h0005, 32'h0000_097F);
    // one lost but the timestamp is too early: discard
    send(OP_PACKET, 16'h0007, 32'h0000_0A7F);
    // duplicate, then a late one
    send(OP_PACKET, 16'h0007, 32'h0000_0B7F);
    send(OP_PACKET, 16'h0003, 32'h0000_0C00);
    // timer silence and a play
    send(OP_TIMER, 16'h5A5A, 32'hA5A5_A5A5);
    send(OP_SINK, 16'hA5A5, 32'h5A5A_5A5A);
    // jump of half the sequence space is not a loss
    send(OP_PACKET, 16'h8004, 32'h0000_0E00);
    // largest loss: silence run fills the buffer and stops on the full store
    send(OP_PACKET, 16'h0004, 32'h0080_0E00);
    // packet and timer into a full buffer
    send(OP_PACKET, 16'h0005, 32'h0080_0F00);
    send(OP_TIMER, 16'h0000, 32'h0000_0000);
    send(OP_SINK, 16'h0000, 32'h0000_0000);
    send(OP_PACKET, 16'h0006, 32'h0080_1000);
    cur_seq = 16'h0006;
    cur_ts  = 32'h0080_1000;

    // empty the buffer and ask twice more with nothing left to play
    repeat (34) send(OP_SINK, SEQ_W'($urandom), $urandom);

    // one sample per block, prefill of one block
    set_config(4'd0, 6'd1);
    repeat (25) random_event();

    // longest block, prefill beyond the buffer depth; no idling on either side
    set_config(4'd15, 6'd63);
    calm = 1'b1;
    repeat (25) random_event();
    calm = 1'b0;

    // middle setting with a full stop of the sender halfway through
    set_config(4'd3, 6'd17);
    repeat (12) random_event();
    drain();
    repeat (12) random_event();

    drain();
    // trailing window to catch any result the block still produces
    repeat (10) @(posedge clk);
    if (faults == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/rgsi_pkg.sv
design/rgsi_ctrl.sv
design/rgsi_datapath.sv
design/rtp_gap_silence_inserter_core.sv
dv/rgsi_playout_checker.sv
dv/tb_top.sv
